[hw/rtl/rvc_pkg.sv]
package rvc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // Q30 angle constants
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] KINV_Q30    = 35'sd652032874;
  // Q3.12 angle constants
  localparam logic signed [17:0] PI_Q12      = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12  = 18'sd25736;

  // config register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_DAMP  = 3'd1;
  localparam logic [2:0] CFG_LIN   = 3'd2;
  localparam logic [2:0] CFG_TURN  = 3'd3;
  localparam logic [2:0] CFG_STEP  = 3'd4;
  localparam logic [2:0] CFG_LIMIT = 3'd5;

  typedef struct packed {
    logic        holo;
    logic [23:0] damp;
    logic [23:0] lin;
    logic [23:0] turn;
    logic [15:0] ts;
    logic [30:0] vmax;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SC_INIT,
    OP_SC_ITER,
    OP_SC_DONE,
    OP_AT_ITER,
    OP_AT_DONE,
    OP_PX,
    OP_PY,
    OP_PSUM,
    OP_LIN_MUL,
    OP_LIN_RND,
    OP_TURN_MUL,
    OP_TURN_RND,
    OP_HDRV,
    OP_DAMP,
    OP_ACC,
    OP_STEP,
    OP_UPD,
    OP_SQA,
    OP_SQB,
    OP_SUM,
    OP_LIM,
    OP_SQ_INIT,
    OP_SQ_ITER,
    OP_DIVM,
    OP_DIV_INIT,
    OP_DIV_ITER,
    OP_DIV_DONE,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
    logic       sel;
  } cmd_t;

  // arctan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd843314856;
      5'd1:    r = 30'd497837829;
      5'd2:    r = 30'd263043836;
      5'd3:    r = 30'd133525158;
      5'd4:    r = 30'd67021686;
      5'd5:    r = 30'd33543515;
      5'd6:    r = 30'd16775850;
      5'd7:    r = 30'd8388437;
      5'd8:    r = 30'd4194282;
      5'd9:    r = 30'd2097149;
      5'd10:   r = 30'd1048575;
      5'd11:   r = 30'd524287;
      5'd12:   r = 30'd262143;
      5'd13:   r = 30'd131071;
      5'd14:   r = 30'd65535;
      5'd15:   r = 30'd32767;
      5'd16:   r = 30'd16383;
      5'd17:   r = 30'd8191;
      5'd18:   r = 30'd4095;
      5'd19:   r = 30'd2047;
      5'd20:   r = 30'd1023;
      5'd21:   r = 30'd511;
      5'd22:   r = 30'd255;
      5'd23:   r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/rvc_ctrl.sv]
module rvc_ctrl #(
  parameter int CORDIC_STEPS = rvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          holo,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          over,
  output rvc_pkg::cmd_t cmd
);

  localparam logic [5:0] STEPS_LAST = 6'(CORDIC_STEPS - 1);
  localparam logic [5:0] SQRT_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST   = 6'd32;

  typedef enum logic [29:0] {
    ST_IDLE     = 30'h00000001,
    ST_SC_INIT  = 30'h00000002,
    ST_SC_ITER  = 30'h00000004,
    ST_SC_DONE  = 30'h00000008,
    ST_AT_ITER  = 30'h00000010,
    ST_AT_DONE  = 30'h00000020,
    ST_PX       = 30'h00000040,
    ST_PY       = 30'h00000080,
    ST_PSUM     = 30'h00000100,
    ST_LIN_MUL  = 30'h00000200,
    ST_LIN_RND  = 30'h00000400,
    ST_TURN_MUL = 30'h00000800,
    ST_TURN_RND = 30'h00001000,
    ST_HDRV     = 30'h00002000,
    ST_DAMP     = 30'h00004000,
    ST_ACC      = 30'h00008000,
    ST_STEP     = 30'h00010000,
    ST_UPD      = 30'h00020000,
    ST_SQA      = 30'h00040000,
    ST_SQB      = 30'h00080000,
    ST_SUM      = 30'h00100000,
    ST_LIM      = 30'h00200000,
    ST_CMP      = 30'h00400000,
    ST_SQ_INIT  = 30'h00800000,
    ST_SQ_ITER  = 30'h01000000,
    ST_DIVM     = 30'h02000000,
    ST_DIV_INIT = 30'h04000000,
    ST_DIV_ITER = 30'h08000000,
    ST_DIV_DONE = 30'h10000000,
    ST_WRITE    = 30'h20000000
  } state_t;

  state_t        state, state_next;
  logic [5:0]    cnt, cnt_next;
  logic          sel, sel_next;
  logic          ovld, ovld_next;
  rvc_pkg::op_t  op;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = ovld;
  assign cmd.op    = op;
  assign cmd.idx   = cnt[4:0];
  assign cmd.sel   = sel;

  always_comb begin
    state_next = state;
    cnt_next   = 6'd0;
    sel_next   = sel;
    ovld_next  = (ovld && !out_stall) ? 1'b0 : ovld;
    op         = rvc_pkg::OP_IDLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = rvc_pkg::OP_LOAD;
          sel_next   = 1'b0;
          state_next = holo ? ST_HDRV : ST_SC_INIT;
        end
      end
      ST_SC_INIT: begin
        op         = rvc_pkg::OP_SC_INIT;
        state_next = ST_SC_ITER;
      end
      ST_SC_ITER: begin
        op = rvc_pkg::OP_SC_ITER;
        if (cnt == STEPS_LAST) state_next = ST_SC_DONE;
        else cnt_next = cnt + 6'd1;
      end
      ST_SC_DONE: begin
        op         = rvc_pkg::OP_SC_DONE;
        state_next = ST_AT_ITER;
      end
      ST_AT_ITER: begin
        op = rvc_pkg::OP_AT_ITER;
        if (cnt == STEPS_LAST) state_next = ST_AT_DONE;
        else cnt_next = cnt + 6'd1;
      end
      ST_AT_DONE: begin
        op         = rvc_pkg::OP_AT_DONE;
        state_next = ST_PX;
      end
      ST_PX: begin
        op         = rvc_pkg::OP_PX;
        state_next = ST_PY;
      end
      ST_PY: begin
        op         = rvc_pkg::OP_PY;
        state_next = ST_PSUM;
      end
      ST_PSUM: begin
        op         = rvc_pkg::OP_PSUM;
        state_next = ST_LIN_MUL;
      end
      ST_LIN_MUL: begin
        op         = rvc_pkg::OP_LIN_MUL;
        state_next = ST_LIN_RND;
      end
      ST_LIN_RND: begin
        op         = rvc_pkg::OP_LIN_RND;
        state_next = ST_DAMP;
      end
      ST_TURN_MUL: begin
        op         = rvc_pkg::OP_TURN_MUL;
        state_next = ST_TURN_RND;
      end
      ST_TURN_RND: begin
        op         = rvc_pkg::OP_TURN_RND;
        state_next = ST_DAMP;
      end
      ST_HDRV: begin
        op         = rvc_pkg::OP_HDRV;
        state_next = ST_DAMP;
      end
      ST_DAMP: begin
        op         = rvc_pkg::OP_DAMP;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        op         = rvc_pkg::OP_ACC;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        op         = rvc_pkg::OP_STEP;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        op = rvc_pkg::OP_UPD;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = holo ? ST_HDRV : ST_TURN_MUL;
        end else begin
          state_next = holo ? ST_SQA : ST_WRITE;
        end
      end
      ST_SQA: begin
        op         = rvc_pkg::OP_SQA;
        state_next = ST_SQB;
      end
      ST_SQB: begin
        op         = rvc_pkg::OP_SQB;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        op         = rvc_pkg::OP_SUM;
        state_next = ST_LIM;
      end
      ST_LIM: begin
        op         = rvc_pkg::OP_LIM;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = over ? ST_SQ_INIT : ST_WRITE;
      end
      ST_SQ_INIT: begin
        op         = rvc_pkg::OP_SQ_INIT;
        state_next = ST_SQ_ITER;
      end
      ST_SQ_ITER: begin
        op = rvc_pkg::OP_SQ_ITER;
        if (cnt == SQRT_LAST) begin
          sel_next   = 1'b0;
          state_next = ST_DIVM;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DIVM: begin
        op         = rvc_pkg::OP_DIVM;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        op         = rvc_pkg::OP_DIV_INIT;
        state_next = ST_DIV_ITER;
      end
      ST_DIV_ITER: begin
        op = rvc_pkg::OP_DIV_ITER;
        if (cnt == DIV_LAST) state_next = ST_DIV_DONE;
        else cnt_next = cnt + 6'd1;
      end
      ST_DIV_DONE: begin
        op = rvc_pkg::OP_DIV_DONE;
        if (!sel) begin
          sel_next   = 1'b1;
          state_next = ST_DIVM;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!ovld || !out_stall) begin
          op         = rvc_pkg::OP_WRITE;
          ovld_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 6'd0;
      sel   <= 1'b0;
      ovld  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      ovld  <= ovld_next;
    end
  end

endmodule

[hw/rtl/rvc_datapath.sv]
module rvc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rvc_pkg::cmd_t       cmd,
  input  rvc_pkg::cfg_t       cfg,
  input  logic signed [31:0]  force_x,
  input  logic signed [31:0]  force_y,
  input  logic signed [14:0]  heading,
  output logic                over,
  output logic signed [31:0]  speed_a,
  output logic signed [31:0]  speed_b
);

  localparam logic signed [44:0] SAT_HI = 45'sd2147483647;
  localparam logic signed [44:0] SAT_LO = -45'sd2147483648;

  // operand / working registers
  logic signed [31:0] fx, fy, v1, v2, cc, cs, oa, ob;
  logic signed [14:0] hd;
  logic signed [59:0] cx, cy;
  logic signed [34:0] cz;
  logic               cneg;
  logic signed [65:0] prod;
  logic signed [63:0] phold;
  logic signed [34:0] proj;
  logic signed [42:0] drv;
  logic signed [43:0] acc;
  logic signed [17:0] errq;
  logic [63:0]        sumr, srem, sroot, sbit;
  logic [32:0]        drem, dq;
  logic               dneg;

  // multipliers
  logic signed [35:0] mw_a, mw_b;
  logic signed [71:0] mw_p;
  logic signed [43:0] mt_a;
  logic signed [16:0] mt_b;
  logic signed [60:0] mt_p;

  // combinational temporaries
  logic signed [31:0] vsel;
  logic signed [34:0] hz, at, zr;
  logic signed [59:0] xs, ys, ax, ay;
  logic signed [16:0] tgt;
  logic signed [17:0] e0, ew;
  logic signed [64:0] ps;
  logic signed [65:0] rr16, rr12;
  logic signed [44:0] nv;
  logic signed [31:0] vs, vc;
  logic [63:0]        st;
  logic [65:0]        mag;
  logic [33:0]        r2, nn;
  logic [31:0]        qres;

  assign vsel = cmd.sel ? v2 : v1;
  assign mw_p = mw_a * mw_b;
  assign mt_a = acc;
  assign mt_b = 17'(cfg.ts);
  assign mt_p = mt_a * mt_b;
  assign over = (sumr > prod[63:0]);
  assign speed_a = oa;
  assign speed_b = ob;

  always_comb begin
    mw_a = '0;
    mw_b = '0;
    case (cmd.op)
      rvc_pkg::OP_PX:       begin mw_a = 36'(fx);        mw_b = 36'(cc);   end
      rvc_pkg::OP_PY:       begin mw_a = 36'(fy);        mw_b = 36'(cs);   end
      rvc_pkg::OP_LIN_MUL:  begin mw_a = 36'(cfg.lin);   mw_b = 36'(proj); end
      rvc_pkg::OP_TURN_MUL: begin mw_a = 36'(cfg.turn);  mw_b = 36'(errq); end
      rvc_pkg::OP_DAMP:     begin mw_a = 36'(cfg.damp);  mw_b = 36'(vsel); end
      rvc_pkg::OP_SQA:      begin mw_a = 36'(v1);        mw_b = 36'(v1);   end
      rvc_pkg::OP_SQB:      begin mw_a = 36'(v2);        mw_b = 36'(v2);   end
      rvc_pkg::OP_LIM:      begin mw_a = 36'(cfg.vmax);  mw_b = 36'(cfg.vmax); end
      rvc_pkg::OP_DIVM:     begin mw_a = 36'(cfg.vmax);  mw_b = 36'(vsel); end
      default: begin
        mw_a = '0;
        mw_b = '0;
      end
    endcase
  end

  always_comb begin
    // CORDIC helpers
    hz = {{2{hd[14]}}, hd, 18'd0};
    at = $signed({5'd0, rvc_pkg::atan_q30(cmd.idx)});
    xs = cx >>> cmd.idx;
    ys = cy >>> cmd.idx;
    ax = {{4{fx[31]}}, fx, 24'd0};
    ay = {{4{fy[31]}}, fy, 24'd0};
    // angle error, wrapped once
    zr = cz + 35'sd131072;
    tgt = (fx == 32'sd0 && fy == 32'sd0) ? 17'(hd) : $signed(zr[34:18]);
    e0 = 18'(tgt) - 18'(hd);
    if (e0 > rvc_pkg::PI_Q12) ew = e0 - rvc_pkg::TWO_PI_Q12;
    else if (e0 < -rvc_pkg::PI_Q12) ew = e0 + rvc_pkg::TWO_PI_Q12;
    else ew = e0;
    // projection sum, round to nearest
    ps = 65'(phold) + 65'($signed(prod[63:0])) + 65'sd536870912;
    rr16 = prod + 66'sd32768;
    rr12 = prod + 66'sd2048;
    // speed update with saturation and forward clamp
    nv = 45'(vsel) + 45'($signed(rr16[59:16]));
    if (nv > SAT_HI) vs = 32'sh7FFFFFFF;
    else if (nv < SAT_LO) vs = 32'sh80000000;
    else vs = 32'(nv);
    if (!cfg.holo && !cmd.sel && (33'(vs) > $signed({2'b00, cfg.vmax})))
      vc = $signed({1'b0, cfg.vmax});
    else
      vc = vs;
    // square root step
    st = sroot + sbit;
    // divider step
    mag = prod[65] ? 66'(-prod) : 66'(prod);
    r2 = {drem, dq[32]};
    nn = {2'b00, sroot[31:0]};
    qres = dneg ? 32'(-dq[31:0]) : dq[31:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rvc_pkg::OP_LOAD: begin
        fx <= force_x;
        fy <= force_y;
        hd <= heading;
      end
      rvc_pkg::OP_SC_INIT: begin
        cx <= 60'(rvc_pkg::KINV_Q30);
        cy <= '0;
        if (hz > rvc_pkg::HALF_PI_Q30) begin
          cz   <= hz - rvc_pkg::PI_Q30;
          cneg <= 1'b1;
        end else if (hz < -rvc_pkg::HALF_PI_Q30) begin
          cz   <= hz + rvc_pkg::PI_Q30;
          cneg <= 1'b1;
        end else begin
          cz   <= hz;
          cneg <= 1'b0;
        end
      end
      rvc_pkg::OP_SC_ITER: begin
        if (!cz[34]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
      end
      rvc_pkg::OP_SC_DONE: begin
        cc <= cneg ? 32'(-cx) : 32'(cx);
        cs <= cneg ? 32'(-cy) : 32'(cy);
        // atan2 setup: fold left half plane by pi
        if (fx[31]) begin
          cz <= fy[31] ? -rvc_pkg::PI_Q30 : rvc_pkg::PI_Q30;
          cx <= -ax;
          cy <= -ay;
        end else begin
          cz <= '0;
          cx <= ax;
          cy <= ay;
        end
      end
      rvc_pkg::OP_AT_ITER: begin
        if (!cy[59]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end
      end
      rvc_pkg::OP_AT_DONE:  errq  <= ew;
      rvc_pkg::OP_PX:       phold <= mw_p[63:0];
      rvc_pkg::OP_PY:       prod  <= mw_p[65:0];
      rvc_pkg::OP_PSUM:     proj  <= ps[64:30];
      rvc_pkg::OP_LIN_MUL:  prod  <= mw_p[65:0];
      rvc_pkg::OP_LIN_RND:  drv   <= rr16[58:16];
      rvc_pkg::OP_TURN_MUL: prod  <= mw_p[65:0];
      rvc_pkg::OP_TURN_RND: drv   <= rr12[54:12];
      rvc_pkg::OP_HDRV:     drv   <= cmd.sel ? 43'(fy) : 43'(fx);
      rvc_pkg::OP_DAMP:     prod  <= mw_p[65:0];
      rvc_pkg::OP_ACC:      acc   <= 44'(drv) - 44'($signed(rr16[56:16]));
      rvc_pkg::OP_STEP:     prod  <= 66'(mt_p);
      rvc_pkg::OP_SQA:      prod  <= mw_p[65:0];
      rvc_pkg::OP_SQB: begin
        sumr <= prod[63:0];
        prod <= mw_p[65:0];
      end
      rvc_pkg::OP_SUM:      sumr  <= sumr + prod[63:0];
      rvc_pkg::OP_LIM:      prod  <= mw_p[65:0];
      rvc_pkg::OP_SQ_INIT: begin
        srem  <= sumr;
        sroot <= '0;
        sbit  <= 64'h4000_0000_0000_0000;
      end
      rvc_pkg::OP_SQ_ITER: begin
        if (srem >= st) begin
          srem  <= srem - st;
          sroot <= (sroot >> 1) + sbit;
        end else begin
          sroot <= sroot >> 1;
        end
        sbit <= sbit >> 2;
      end
      rvc_pkg::OP_DIVM:     prod  <= mw_p[65:0];
      rvc_pkg::OP_DIV_INIT: begin
        dneg <= prod[65];
        drem <= {3'b000, mag[62:33]};
        dq   <= mag[32:0];
      end
      rvc_pkg::OP_DIV_ITER: begin
        if (r2 >= nn) begin
          drem <= 33'(r2 - nn);
          dq   <= {dq[31:0], 1'b1};
        end else begin
          drem <= r2[32:0];
          dq   <= {dq[31:0], 1'b0};
        end
      end
      rvc_pkg::OP_WRITE: begin
        oa <= v1;
        ob <= v2;
      end
      default: begin
      end
    endcase
  end

  // stored speeds
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= '0;
      v2 <= '0;
    end else if (cmd.op == rvc_pkg::OP_UPD) begin
      if (cmd.sel) v2 <= vc;
      else v1 <= vc;
    end else if (cmd.op == rvc_pkg::OP_DIV_DONE) begin
      if (cmd.sel) v2 <= $signed(qres);
      else v1 <= $signed(qres);
    end
  end

endmodule

[hw/rtl/robot_velocity_controller.sv]
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    force_x, force_y, heading
// out       out  out_valid / out_stall  speed_a, speed_b
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word in, one word out. In differential mode the run time is set by
// the two CORDIC passes on one shared x/y/z unit. Holonomic mode takes a
// longer path when the speed vector is rescaled: a square root and two
// restoring divisions. Reset (rst, synchronous) clears the stored speeds
// and loads the register defaults. The result sits in an output register;
// the controller only blocks at its final write while an earlier result is
// still stalled.
module robot_velocity_controller #(
  parameter int CORDIC_STEPS = rvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input word
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [14:0] heading,
  // result word
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] speed_a,
  output logic signed [31:0] speed_b,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  rvc_pkg::cfg_t cfg;
  rvc_pkg::cmd_t cmd;
  logic          over;

  // registers are always writable; writes land only while idle by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.holo <= 1'b0;
      cfg.damp <= 24'd65536;
      cfg.lin  <= 24'd65536;
      cfg.turn <= 24'd65536;
      cfg.ts   <= 16'd6554;
      cfg.vmax <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        rvc_pkg::CFG_MODE:  cfg.holo <= cfg_data[0];
        rvc_pkg::CFG_DAMP:  cfg.damp <= cfg_data[23:0];
        rvc_pkg::CFG_LIN:   cfg.lin  <= cfg_data[23:0];
        rvc_pkg::CFG_TURN:  cfg.turn <= cfg_data[23:0];
        rvc_pkg::CFG_STEP:  cfg.ts   <= cfg_data[15:0];
        rvc_pkg::CFG_LIMIT: cfg.vmax <= cfg_data;
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // sequencer: walks the op list for the selected mode, with a rescale branch in holonomic mode
  rvc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .holo      (cfg.holo),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .over      (over),
    .cmd       (cmd)
  );

  // arithmetic: CORDIC, two multipliers, sqrt and divider steps, speed state
  rvc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .cfg     (cfg),
    .force_x (force_x),
    .force_y (force_y),
    .heading (heading),
    .over    (over),
    .speed_a (speed_a),
    .speed_b (speed_b)
  );

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // index with no register behind it; the block must drop the write
  localparam logic [2:0] CFG_UNUSED_A = 3'd6;
  localparam logic [2:0] CFG_UNUSED_B = 3'd7;
  localparam int         ANGLE_STEPS  = rvc_pkg::CORDIC_STEPS_DEF;
  // slowest word is the rescale path; wait that long plus margin
  localparam int         SETTLE_CYCLES = 160;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] force_x = '0;
  logic signed [31:0] force_y = '0;
  logic signed [14:0] heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] speed_a;
  logic signed [31:0] speed_b;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [30:0]        cfg_data = '0;

  robot_velocity_controller dut (.*);

  always #4 clk = ~clk;

  // expected speeds, oldest first
  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } speed_pair_t;
  speed_pair_t pending_speeds[$];

  int errors        = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int reg_writes    = 0;
  int rescales      = 0;
  int clamps        = 0;

  // idling knobs: src_gaps for the sender, sink_stalls for the receiver
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  int hold_cnt    = 0;

  // shadow registers and stored speeds
  logic        holo_r;
  logic [23:0] damp_r, lin_r, turn_r;
  logic [15:0] ts_r;
  logic [30:0] vmax_r;
  logic signed [31:0] spd1, spd2;

  longint angle_tab[ANGLE_STEPS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850,
    8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767
  };

  //--------------------------------------------------------------------------
  // predictor
  //--------------------------------------------------------------------------
  function automatic longint rnd_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] damped_euler(logic signed [31:0] v, longint drive);
    longint acc;
    acc = drive - rnd_shr(longint'(damp_r) * longint'(v), 16);
    return clip32(longint'(v) + rnd_shr(acc * longint'(ts_r), 16));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rotation of the unit vector by z (Q30), returns cos and sin in Q30
  function automatic void rotate_unit(longint z, output longint c, output longint s);
    longint x, y, nx;
    bit     flip;
    x = longint'(rvc_pkg::KINV_Q30);
    y = 0;
    flip = 1'b0;
    if (z > longint'(rvc_pkg::HALF_PI_Q30)) begin
      z = z - longint'(rvc_pkg::PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(rvc_pkg::HALF_PI_Q30)) begin
      z = z + longint'(rvc_pkg::PI_Q30);
      flip = 1'b1;
    end
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - angle_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + angle_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(rvc_pkg::PI_Q30) : -longint'(rvc_pkg::PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + angle_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - angle_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic speed_pair_t predict_speeds(logic signed [31:0] fx32,
                                                 logic signed [31:0] fy32,
                                                 logic signed [14:0] h15);
    speed_pair_t       r;
    longint            fx, fy, h, a, b, n, c, s, proj, target, err;
    longint unsigned   sum, lim2;
    fx = fx32;
    fy = fy32;
    h  = h15;
    if (holo_r) begin
      spd1 = damped_euler(spd1, fx);
      spd2 = damped_euler(spd2, fy);
      a = spd1;
      b = spd2;
      sum  = longint'(a * a) + longint'(b * b);
      lim2 = longint'(vmax_r) * longint'(vmax_r);
      if (sum > lim2) begin
        rescales++;
        n = longint'(int_sqrt(sum));
        spd1 = 32'((longint'(vmax_r) * a) / n);
        spd2 = 32'((longint'(vmax_r) * b) / n);
      end
    end else begin
      rotate_unit(h * 262144, c, s);
      proj = rnd_shr(fx * c + fy * s, 30);
      if (fx == 0 && fy == 0) target = h;
      else target = rnd_shr(vector_angle(fy * 16777216, fx * 16777216), 18);
      err = target - h;
      if (err > longint'(rvc_pkg::PI_Q12)) err = err - longint'(rvc_pkg::TWO_PI_Q12);
      else if (err < -longint'(rvc_pkg::PI_Q12)) err = err + longint'(rvc_pkg::TWO_PI_Q12);
      spd1 = damped_euler(spd1, rnd_shr(longint'(lin_r) * proj, 16));
      spd2 = damped_euler(spd2, rnd_shr(longint'(turn_r) * err, 12));
      // forward speed limited from above only
      if (longint'(spd1) > longint'(vmax_r)) begin
        clamps++;
        spd1 = $signed({1'b0, vmax_r});
      end
    end
    r.a = spd1;
    r.b = spd2;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // result checker, sampled at the rising edge
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    speed_pair_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_speeds.size() == 0) begin
        errors++;
        $display("%t: result word with nothing expected: a=%0d b=%0d", $realtime,
                 speed_a, speed_b);
      end else begin
        exp_w = pending_speeds.pop_front();
        words_checked++;
        if (speed_a !== exp_w.a) begin
          errors++;
          $display("%t: speed_a expected %0d actual %0d", $realtime, exp_w.a, speed_a);
        end
        if (speed_b !== exp_w.b) begin
          errors++;
          $display("%t: speed_b expected %0d actual %0d", $realtime, exp_w.b, speed_b);
        end
      end
    end
  end

  // receiver stall: random, calm, or a long counted hold-off
  always @(negedge clk) begin
    logic st;
    if (hold_cnt > 0) begin
      st = 1'b1;
      hold_cnt = hold_cnt - 1;
    end else if (sink_stalls) begin
      st = ($urandom_range(99) < 25);
    end else begin
      st = 1'b0;
    end
    out_stall <= st;
  end

  //--------------------------------------------------------------------------
  // drivers; all called at a falling edge and return at one
  //--------------------------------------------------------------------------
  task automatic send_word(logic signed [31:0] fx, logic signed [31:0] fy,
                           logic signed [14:0] h);
    bit taken;
    if (src_gaps && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    force_x  <= fx;
    force_y  <= fy;
    heading  <= h;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_valid && !in_stall;
    end
    pending_speeds.push_back(predict_speeds(fx, fy, h));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    case (idx)
      rvc_pkg::CFG_MODE:  holo_r = val[0];
      rvc_pkg::CFG_DAMP:  damp_r = val[23:0];
      rvc_pkg::CFG_LIN:   lin_r  = val[23:0];
      rvc_pkg::CFG_TURN:  turn_r = val[23:0];
      rvc_pkg::CFG_STEP:  ts_r   = val[15:0];
      rvc_pkg::CFG_LIMIT: vmax_r = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_force();
    case ($urandom_range(9))
      0:       return 32'sd0;
      1:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
    endcase
  endfunction

  function automatic logic signed [14:0] pick_heading();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(0, 25736)) - 32'sd12868);
  endfunction

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(7))
      0:       return 31'd0;
      1:       return 31'hFFFFFF;
      2:       return 31'($urandom & 32'hFFFFFF);
      default: return 31'($urandom_range(1 << 13, 1 << 19));
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // tests
  //--------------------------------------------------------------------------

  // reset defaults, differential drive: zero force, force extremes, heading
  // at +/-pi and beyond, reverse forward speed, error wrap across pi
  task automatic test_differential_directed();
    send_word(0, 0, 15'sd0);
    send_word(0, 0, 15'sd12868);
    send_word(0, 0, -15'sd12868);
    send_word(32'sh7FFFFFFF, 0, 15'sd0);
    send_word(32'sh80000000, 0, 15'sd0);
    send_word(0, 32'sh7FFFFFFF, 15'sd6434);
    send_word(0, 32'sh80000000, -15'sd6434);
    send_word(32'sd65536, 32'sd65536, 15'sd0);
    send_word(-32'sd65536, 0, 15'sd0);
    send_word(-32'sd65536, 32'sd1, 15'sd12868);
    send_word(-32'sd65536, -32'sd1, -15'sd12868);
    send_word(32'sd100, 0, 15'sd16383);
    send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, -15'sd16384);
    send_word(0, 0, -15'sd16384);
    wait_idle();
  endtask

  // holonomic: stored speeds carried over across the mode change, rescale
  // to the limit, and a zero limit
  task automatic test_holonomic_directed();
    write_reg(rvc_pkg::CFG_MODE, 31'd1);
    send_word(32'sd65536, -32'sd65536, 15'sd0);
    send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 15'sd0);
    send_word(32'sh80000000, 32'sh7FFFFFFF, 15'sd0);
    send_word(0, 0, 15'sd0);
    wait_idle();
    write_reg(rvc_pkg::CFG_LIMIT, 31'd0);
    send_word(32'sd1000, 32'sd2000, 15'sd0);
    send_word(0, 0, 15'sd0);
    wait_idle();
    write_reg(rvc_pkg::CFG_LIMIT, 31'h7FFFFFFF);
    send_word(32'sh80000000, 32'sh80000000, 15'sd0);
    send_word(32'sh7FFFFFFF, 32'sh80000000, 15'sd0);
    wait_idle();
  endtask

  // every gain, step and limit register at both ends, writes to unused indexes are dropped
  task automatic test_register_extremes();
    write_reg(CFG_UNUSED_A, 31'h7FFFFFFF);
    write_reg(CFG_UNUSED_B, 31'd0);
    write_reg(rvc_pkg::CFG_MODE, 31'd0);
    write_reg(rvc_pkg::CFG_DAMP, 31'hFFFFFF);
    write_reg(rvc_pkg::CFG_LIN, 31'hFFFFFF);
    write_reg(rvc_pkg::CFG_TURN, 31'hFFFFFF);
    write_reg(rvc_pkg::CFG_STEP, 31'hFFFF);
    write_reg(rvc_pkg::CFG_LIMIT, 31'd0);
    send_word(32'sh7FFFFFFF, 32'sd5, 15'sd100);
    send_word(32'sh80000000, 32'sh80000000, -15'sd9000);
    send_word(-32'sd70000, 32'sd3, 15'sd12000);
    wait_idle();
    write_reg(rvc_pkg::CFG_DAMP, 31'd0);
    write_reg(rvc_pkg::CFG_LIN, 31'd0);
    write_reg(rvc_pkg::CFG_TURN, 31'd0);
    write_reg(rvc_pkg::CFG_STEP, 31'd0);
    write_reg(rvc_pkg::CFG_LIMIT, 31'h7FFFFFFF);
    send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 15'sd3000);
    send_word(32'sd12345, -32'sd999, -15'sd3000);
    wait_idle();
  endtask

  // receiver holds off while words keep coming, then the sender waits out
  // every result before going on
  task automatic test_backpressure();
    write_reg(rvc_pkg::CFG_MODE, 31'd0);
    write_reg(rvc_pkg::CFG_DAMP, 31'd65536);
    write_reg(rvc_pkg::CFG_LIN, 31'd65536);
    write_reg(rvc_pkg::CFG_TURN, 31'd65536);
    write_reg(rvc_pkg::CFG_STEP, 31'd6554);
    write_reg(rvc_pkg::CFG_LIMIT, 31'd655360);
    hold_cnt = 400;
    for (int i = 0; i < 12; i++) send_word(pick_force(), pick_force(), pick_heading());
    wait_idle();
  endtask

  // random phases, each with its own register setting; one phase with no
  // idling on either side
  task automatic test_random_phases();
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(rvc_pkg::CFG_MODE, 31'($urandom_range(1)));
      write_reg(rvc_pkg::CFG_DAMP, pick_gain());
      write_reg(rvc_pkg::CFG_LIN, pick_gain());
      write_reg(rvc_pkg::CFG_TURN, pick_gain());
      write_reg(rvc_pkg::CFG_STEP, 31'($urandom_range(3) == 0 ? $urandom & 32'hFFFF
                                                 : $urandom_range(100, 20000)));
      write_reg(rvc_pkg::CFG_LIMIT, 31'($urandom_range(3) == 0 ? $urandom & 32'h7FFFFFFF
                                                  : $urandom_range(0, 32'h400000)));
      src_gaps    = (ph != 4);
      sink_stalls = (ph != 4);
      for (int i = 0; i < 70; i++) send_word(pick_force(), pick_force(), pick_heading());
      wait_idle();
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  //--------------------------------------------------------------------------
  // main sequence
  //--------------------------------------------------------------------------
  initial begin
    holo_r = 1'b0;
    damp_r = 24'd65536;
    lin_r  = 24'd65536;
    turn_r = 24'd65536;
    ts_r   = 16'd6554;
    vmax_r = 31'd65536;
    spd1   = '0;
    spd2   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_differential_directed();
    test_holonomic_directed();
    test_register_extremes();
    test_backpressure();
    test_random_phases();

    wait_idle();
    $display("covered %0d words, %0d checked, %0d register writes", words_sent,
             words_checked, reg_writes);
    $display("limit events: %0d vector rescales, %0d forward clamps", rescales, clamps);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d words outstanding", pending_speeds.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule

[files.f]
hw/rtl/rvc_pkg.sv
hw/rtl/rvc_ctrl.sv
hw/rtl/rvc_datapath.sv
hw/rtl/robot_velocity_controller.sv
verif/tb.sv
